// File: hw/rtl/idq_pkg.sv
// Shared types, constants and slot arithmetic for the indexed deque engine.
`default_nettype none

package idq_pkg;

   localparam int CAPACITY = 1024;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KIND_W   = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_POP_BACK   = 3'd1,
      KIND_PUSH_FRONT = 3'd2,
      KIND_POP_FRONT  = 3'd3,
      KIND_INSERT     = 3'd4,
      KIND_REMOVE     = 3'd5,
      KIND_READ       = 3'd6,
      KIND_CLEAR      = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RDVAL,
      ST_MOVE,
      ST_WRNEW,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   localparam logic [ADDR_W:0]   CAP_SLOTS = (ADDR_W + 1)'(CAPACITY);
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0]  CAP_COUNT = CNT_W'(CAPACITY);

   function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= CAP_SLOTS) begin
         s = s - CAP_SLOTS;
      end
      return s[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
      return (a == LAST_SLOT) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] a);
      return (a == '0) ? LAST_SLOT : a - 1'b1;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/idq_ram.sv
// Simple dual-port element memory with registered read.
`default_nettype none

module idq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/idq_ctrl.sv
// Operation sequencer: decode, element shift loop, pointer and count update, result.
`default_nettype none

module idq_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire logic [idq_pkg::KIND_W-1:0] req_kind,
   input  wire logic [idq_pkg::CNT_W-1:0]  req_position,
   input  wire logic [idq_pkg::DATA_W-1:0] req_value_in,
   output      logic                       rsp_valid,
   output      logic [idq_pkg::DATA_W-1:0] rsp_value_out,
   output      logic                       rsp_data_valid,
   output      logic                       rsp_done_res,
   output      logic [idq_pkg::CNT_W-1:0]  rsp_count,
   output      idq_pkg::mem_req_type       mem_req,
   input  wire logic [idq_pkg::DATA_W-1:0] rd_data
);

   idq_pkg::state_type state_ff, state_in;
   logic [idq_pkg::ADDR_W-1:0] front_ff, front_in;
   logic [idq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [idq_pkg::ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [idq_pkg::ADDR_W-1:0] last_ff, last_in;
   logic [idq_pkg::ADDR_W-1:0] tgt_ff, tgt_in;
   logic [idq_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic                       up_ff, up_in;
   logic                       wr_pend_ff, wr_pend_in;
   logic                       cap_ff, cap_in;
   logic                       ins_ff, ins_in;
   logic [idq_pkg::DATA_W-1:0] val_ff, val_in;
   logic [idq_pkg::DATA_W-1:0] vin_ff, vin_in;
   logic                       done_ff, done_in;
   logic                       dv_ff, dv_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [idq_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                       rsp_dv_ff, rsp_dv_in;
   logic                       rsp_done_ff, rsp_done_in;
   logic [idq_pkg::CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   idq_pkg::kind_type          kind;
   logic [idq_pkg::CNT_W-1:0]  pos_eff;
   logic [idq_pkg::ADDR_W-1:0] pos_a;
   logic [idq_pkg::ADDR_W-1:0] cnt_m1_a;
   logic [idq_pkg::ADDR_W-1:0] at_pos;
   logic [idq_pkg::CNT_W-1:0]  half;
   logic                       is_ins, is_rem, is_read;
   logic                       ins_ok, rem_ok, rd_ok;

   assign kind     = idq_pkg::kind_type'(req_kind);
   assign half     = count_ff >> 1;
   assign pos_a    = pos_eff[idq_pkg::ADDR_W-1:0];
   assign cnt_m1_a = idq_pkg::ADDR_W'(count_ff - 1'b1);
   assign at_pos   = idq_pkg::slot_add(front_ff, pos_a);
   assign ins_ok   = (pos_eff <= count_ff) && (count_ff < idq_pkg::CAP_COUNT);
   assign rem_ok   = (count_ff != '0) && (pos_eff < count_ff);
   assign rd_ok    = pos_eff < count_ff;
   assign busy     = state_ff != idq_pkg::ST_IDLE;

   always_comb begin
      pos_eff = req_position;
      is_ins  = 1'b0;
      is_rem  = 1'b0;
      is_read = 1'b0;
      unique case (kind)
         idq_pkg::KIND_PUSH_BACK: begin
            pos_eff = count_ff;
            is_ins  = 1'b1;
         end
         idq_pkg::KIND_POP_BACK: begin
            pos_eff = count_ff - 1'b1;
            is_rem  = 1'b1;
         end
         idq_pkg::KIND_PUSH_FRONT: begin
            pos_eff = '0;
            is_ins  = 1'b1;
         end
         idq_pkg::KIND_POP_FRONT: begin
            pos_eff = '0;
            is_rem  = 1'b1;
         end
         idq_pkg::KIND_INSERT: begin
            is_ins = 1'b1;
         end
         idq_pkg::KIND_REMOVE: begin
            is_rem = 1'b1;
         end
         idq_pkg::KIND_READ: begin
            is_read = 1'b1;
         end
         idq_pkg::KIND_CLEAR: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      last_in      = last_ff;
      tgt_in       = tgt_ff;
      rem_in       = rem_ff;
      up_in        = up_ff;
      wr_pend_in   = 1'b0;
      cap_in       = 1'b0;
      ins_in       = ins_ff;
      val_in       = cap_ff ? rd_data : val_ff;
      vin_in       = vin_ff;
      done_in      = done_ff;
      dv_in        = dv_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_dv_in    = rsp_dv_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_count_in = rsp_count_ff;
      mem_req      = '0;

      unique case (state_ff)
         idq_pkg::ST_IDLE: begin
            if (start) begin
               vin_in   = req_value_in;
               done_in  = 1'b0;
               dv_in    = 1'b0;
               ins_in   = 1'b0;
               rem_in   = '0;
               state_in = idq_pkg::ST_FINISH;
               if (is_ins) begin
                  if (ins_ok) begin
                     done_in  = 1'b1;
                     ins_in   = 1'b1;
                     count_in = count_ff + 1'b1;
                     state_in = idq_pkg::ST_MOVE;
                     if (pos_eff <= half) begin
                        front_in  = idq_pkg::slot_dec(front_ff);
                        rd_ptr_in = front_ff;
                        tgt_in    = idq_pkg::slot_add(idq_pkg::slot_dec(front_ff), pos_a);
                        rem_in    = pos_eff;
                        up_in     = 1'b1;
                     end else begin
                        rd_ptr_in = idq_pkg::slot_add(front_ff, cnt_m1_a);
                        tgt_in    = at_pos;
                        rem_in    = count_ff - pos_eff;
                        up_in     = 1'b0;
                     end
                  end
               end else if (is_rem) begin
                  if (rem_ok) begin
                     done_in  = 1'b1;
                     dv_in    = 1'b1;
                     count_in = count_ff - 1'b1;
                     tgt_in   = at_pos;
                     state_in = idq_pkg::ST_RDVAL;
                     if (pos_eff < half) begin
                        front_in  = idq_pkg::slot_inc(front_ff);
                        rd_ptr_in = idq_pkg::slot_dec(at_pos);
                        rem_in    = pos_eff;
                        up_in     = 1'b0;
                     end else begin
                        rd_ptr_in = idq_pkg::slot_inc(at_pos);
                        rem_in    = count_ff - 1'b1 - pos_eff;
                        up_in     = 1'b1;
                     end
                  end
               end else if (is_read) begin
                  if (rd_ok) begin
                     done_in  = 1'b1;
                     dv_in    = 1'b1;
                     tgt_in   = at_pos;
                     state_in = idq_pkg::ST_RDVAL;
                  end
               end else begin
                  count_in = '0;
                  front_in = '0;
                  done_in  = 1'b1;
               end
            end
         end
         idq_pkg::ST_RDVAL: begin
            mem_req.rd_addr = tgt_ff;
            cap_in          = 1'b1;
            state_in        = idq_pkg::ST_MOVE;
         end
         idq_pkg::ST_MOVE: begin
            if (rem_ff != '0) begin
               mem_req.rd_addr = rd_ptr_ff;
               last_in         = rd_ptr_ff;
               rd_ptr_in       = up_ff ? idq_pkg::slot_inc(rd_ptr_ff)
                                       : idq_pkg::slot_dec(rd_ptr_ff);
               rem_in          = rem_ff - 1'b1;
               wr_pend_in      = 1'b1;
            end
            if (wr_pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = up_ff ? idq_pkg::slot_dec(last_ff)
                                       : idq_pkg::slot_inc(last_ff);
               mem_req.wr_data = rd_data;
            end
            if ((rem_ff == '0) && !wr_pend_ff) begin
               state_in = ins_ff ? idq_pkg::ST_WRNEW : idq_pkg::ST_FINISH;
            end
         end
         idq_pkg::ST_WRNEW: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tgt_ff;
            mem_req.wr_data = vin_ff;
            state_in        = idq_pkg::ST_FINISH;
         end
         idq_pkg::ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = dv_ff ? val_ff : '0;
            rsp_dv_in    = dv_ff;
            rsp_done_in  = done_ff;
            rsp_count_in = count_ff;
            state_in     = idq_pkg::ST_IDLE;
         end
         default: begin
            state_in = idq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= idq_pkg::ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         cap_ff       <= 1'b0;
         ins_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         wr_pend_ff   <= wr_pend_in;
         cap_ff       <= cap_in;
         ins_ff       <= ins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      last_ff      <= last_in;
      tgt_ff       <= tgt_in;
      up_ff        <= up_in;
      val_ff       <= val_in;
      vin_ff       <= vin_in;
      done_ff      <= done_in;
      dv_ff        <= dv_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dv_ff    <= rsp_dv_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_data_valid = rsp_dv_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

`default_nettype wire

// File: hw/rtl/indexed_deque_engine.sv
// Top level of the indexed deque engine: sequencer plus element memory.
// Refused requests and clear go straight to the result. Reads and removals fetch
// the element first; then elements shift, one move per cycle, and insertions write
// the new element last. At most 511 elements shift (at most half the fill level).
// One transaction in flight; the next is accepted at the edge that takes the result.
// Synchronous active-high reset empties the deque; memory contents stay undefined.
`default_nettype none

module indexed_deque_engine (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire logic [idq_pkg::KIND_W-1:0] req_kind,
   input  wire logic [idq_pkg::CNT_W-1:0]  req_position,
   input  wire logic [idq_pkg::DATA_W-1:0] req_value_in,
   output      logic                       rsp_valid,
   output      logic [idq_pkg::DATA_W-1:0] rsp_value_out,
   output      logic                       rsp_data_valid,
   output      logic                       rsp_done_res,
   output      logic [idq_pkg::CNT_W-1:0]  rsp_count
);

   idq_pkg::mem_req_type       mem_req;
   logic [idq_pkg::DATA_W-1:0] rd_data;

   idq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_value_out  (rsp_value_out),
      .rsp_data_valid (rsp_data_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_count      (rsp_count),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   idq_ram #(
      .DEPTH (idq_pkg::CAPACITY),
      .WIDTH (idq_pkg::DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// File: hw/rtl/idq_checker.sv
// Port-level checks for the indexed deque engine and their bind.
`default_nettype none

module idq_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic                       rsp_valid,
   input wire logic [idq_pkg::DATA_W-1:0] rsp_value_out,
   input wire logic                       rsp_data_valid,
   input wire logic                       rsp_done_res,
   input wire logic [idq_pkg::CNT_W-1:0]  rsp_count
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result strobe");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |-> (!rsp_data_valid && (rsp_value_out == '0)))
      else $error("refused transaction returned data");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= idq_pkg::CAP_COUNT))
      else $error("count beyond capacity");

endmodule

bind indexed_deque_engine idq_checker u_idq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_value_out  (rsp_value_out),
   .rsp_data_valid (rsp_data_valid),
   .rsp_done_res   (rsp_done_res),
   .rsp_count      (rsp_count)
);

`default_nettype wire

// File: sim/tb_indexed_deque_engine.sv
// Self-checking testbench for the indexed deque engine: directed and random operations.
module tb_indexed_deque_engine;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      PLACE_FIXED,
      PLACE_LIVE,
      PLACE_END,
      PLACE_WILD
   } place_mode_type;

   typedef struct packed {
      idq_pkg::kind_type                kind;
      place_mode_type                   mode;
      logic [idq_pkg::CNT_W-1:0]        position;
      logic [idq_pkg::DATA_W-1:0]       value;
      logic [4:0]                       gap;
      logic                             hold;
   } deque_op_type;

   typedef struct packed {
      logic [idq_pkg::DATA_W-1:0] value;
      logic                       data_valid;
      logic                       done;
      logic [idq_pkg::CNT_W-1:0]  count;
   } outcome_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [idq_pkg::KIND_W-1:0] req_kind = '0;
   logic [idq_pkg::CNT_W-1:0]  req_position = '0;
   logic [idq_pkg::DATA_W-1:0] req_value_in = '0;
   logic                       rsp_valid;
   logic [idq_pkg::DATA_W-1:0] rsp_value_out;
   logic                       rsp_data_valid;
   logic                       rsp_done_res;
   logic [idq_pkg::CNT_W-1:0]  rsp_count;

   deque_op_type pending_ops[$];
   outcome_type  awaited_outcomes[$];

   logic [idq_pkg::DATA_W-1:0] held [idq_pkg::CAPACITY];
   logic [idq_pkg::ADDR_W-1:0] front_q = '0;
   logic [idq_pkg::CNT_W-1:0]  fill_q = '0;

   int     idle_count = 0;
   int     mismatch_count = 0;
   longint cycle_count = 0;
   longint cycle_limit = 20000;

   indexed_deque_engine dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_value_out  (rsp_value_out),
      .rsp_data_valid (rsp_data_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_count      (rsp_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int ring_index(int k);
      return (int'(front_q) + k) % idq_pkg::CAPACITY;
   endfunction

   function automatic logic place_element(int pos, logic [idq_pkg::DATA_W-1:0] value);
      int k;
      if (pos > int'(fill_q) || int'(fill_q) >= idq_pkg::CAPACITY) begin
         return 1'b0;
      end
      if (pos <= int'(fill_q) / 2) begin
         front_q = front_q - 1'b1;
         for (k = 0; k < pos; k++) begin
            held[ring_index(k)] = held[ring_index(k + 1)];
         end
      end else begin
         for (k = int'(fill_q); k > pos; k--) begin
            held[ring_index(k)] = held[ring_index(k - 1)];
         end
      end
      held[ring_index(pos)] = value;
      fill_q = fill_q + 1'b1;
      return 1'b1;
   endfunction

   function automatic logic take_element(int pos,
                                         output logic [idq_pkg::DATA_W-1:0] taken);
      int k;
      taken = '0;
      if (pos >= int'(fill_q)) begin
         return 1'b0;
      end
      taken = held[ring_index(pos)];
      if (pos < int'(fill_q) / 2) begin
         for (k = pos; k > 0; k--) begin
            held[ring_index(k)] = held[ring_index(k - 1)];
         end
         front_q = idq_pkg::ADDR_W'(ring_index(1));
      end else begin
         for (k = pos; k + 1 < int'(fill_q); k++) begin
            held[ring_index(k)] = held[ring_index(k + 1)];
         end
      end
      fill_q = fill_q - 1'b1;
      return 1'b1;
   endfunction

   function automatic outcome_type deque_apply(idq_pkg::kind_type kind,
                                               logic [idq_pkg::CNT_W-1:0] position,
                                               logic [idq_pkg::DATA_W-1:0] value);
      outcome_type                res;
      logic [idq_pkg::DATA_W-1:0] taken;
      int                         pos;
      res = '0;
      taken = '0;
      pos = int'(position);
      case (kind)
         idq_pkg::KIND_PUSH_BACK:  res.done = place_element(int'(fill_q), value);
         idq_pkg::KIND_PUSH_FRONT: res.done = place_element(0, value);
         idq_pkg::KIND_INSERT:     res.done = place_element(pos, value);
         idq_pkg::KIND_POP_BACK: begin
            if (fill_q != 0) begin
               res.done = take_element(int'(fill_q) - 1, taken);
            end
         end
         idq_pkg::KIND_POP_FRONT:  res.done = take_element(0, taken);
         idq_pkg::KIND_REMOVE:     res.done = take_element(pos, taken);
         idq_pkg::KIND_READ: begin
            if (pos < int'(fill_q)) begin
               taken = held[ring_index(pos)];
               res.done = 1'b1;
            end
         end
         default: begin
            fill_q = '0;
            front_q = '0;
            res.done = 1'b1;
         end
      endcase
      res.data_valid = res.done && (kind == idq_pkg::KIND_POP_BACK ||
                                    kind == idq_pkg::KIND_POP_FRONT ||
                                    kind == idq_pkg::KIND_REMOVE ||
                                    kind == idq_pkg::KIND_READ);
      res.value = res.data_valid ? taken : '0;
      res.count = fill_q;
      return res;
   endfunction

   function automatic logic [idq_pkg::CNT_W-1:0] resolve_position(deque_op_type op);
      int top;
      top = (op.kind == idq_pkg::KIND_INSERT) ? int'(fill_q) : int'(fill_q) - 1;
      case (op.mode)
         PLACE_LIVE: return (top <= 0) ? '0 : idq_pkg::CNT_W'($urandom_range(0, top));
         PLACE_END:  return fill_q;
         PLACE_WILD: return idq_pkg::CNT_W'($urandom_range(0, (1 << idq_pkg::CNT_W) - 1));
         default:    return op.position;
      endcase
   endfunction

   function automatic logic [idq_pkg::DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return '1;
      end
      return idq_pkg::DATA_W'($urandom);
   endfunction

   task automatic add_op(idq_pkg::kind_type kind, place_mode_type mode, int pos,
                         logic [idq_pkg::DATA_W-1:0] value, int gap, logic hold);
      deque_op_type op;
      op.kind = kind;
      op.mode = mode;
      op.position = idq_pkg::CNT_W'(pos);
      op.value = value;
      op.gap = 5'(gap);
      op.hold = hold;
      pending_ops.push_back(op);
      cycle_limit += longint'(gap + 530) * 4;
   endtask

   task automatic add_random_op(int grow, int gap, logic hold);
      int             r;
      int             m;
      place_mode_type mode;
      r = $urandom_range(0, 99);
      m = $urandom_range(0, 9);
      mode = (m == 0) ? PLACE_WILD : (m == 1) ? PLACE_END : PLACE_LIVE;
      if (r < 2) begin
         add_op(idq_pkg::KIND_CLEAR, PLACE_WILD, 0, pick_value(), gap, hold);
      end else if (r < 2 + grow) begin
         case ($urandom_range(0, 3))
            0:       add_op(idq_pkg::KIND_PUSH_BACK, PLACE_WILD, 0, pick_value(), gap, hold);
            1:       add_op(idq_pkg::KIND_PUSH_FRONT, PLACE_WILD, 0, pick_value(), gap, hold);
            default: add_op(idq_pkg::KIND_INSERT, mode, 0, pick_value(), gap, hold);
         endcase
      end else if (r < 17 + grow) begin
         add_op(idq_pkg::KIND_READ, mode, 0, pick_value(), gap, hold);
      end else begin
         case ($urandom_range(0, 3))
            0:       add_op(idq_pkg::KIND_POP_BACK, PLACE_WILD, 0, pick_value(), gap, hold);
            1:       add_op(idq_pkg::KIND_POP_FRONT, PLACE_WILD, 0, pick_value(), gap, hold);
            default: add_op(idq_pkg::KIND_REMOVE, mode, 0, pick_value(), gap, hold);
         endcase
      end
   endtask

   always @(posedge clock) begin
      deque_op_type op;
      logic         free;
      if (reset) begin
         start <= 1'b0;
         idle_count = 0;
      end else begin
         free = !start;
         if (start && !busy) begin
            awaited_outcomes.push_back(deque_apply(idq_pkg::kind_type'(req_kind),
                                                   req_position, req_value_in));
            free = 1'b1;
         end
         if (free) begin
            if (pending_ops.size() != 0 && idle_count >= int'(pending_ops[0].gap) &&
                !(pending_ops[0].hold && awaited_outcomes.size() != 0)) begin
               op = pending_ops.pop_front();
               start <= 1'b1;
               req_kind <= op.kind;
               req_position <= resolve_position(op);
               req_value_in <= op.value;
               idle_count = 0;
            end else begin
               start <= 1'b0;
               if (pending_ops.size() != 0) begin
                  idle_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_value_out, rsp_data_valid, rsp_done_res, rsp_count};
         if (awaited_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected transaction: value %h valid %b done %b count %0d",
                        got.value, got.data_valid, got.done, got.count);
            end
         end else begin
            want = awaited_outcomes.pop_front();
            if (got.value !== want.value || got.data_valid !== want.data_valid ||
                got.done !== want.done || got.count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("expected value %h valid %b done %b count %0d", want.value,
                           want.data_valid, want.done, want.count);
                  $display("  actual value %h valid %b done %b count %0d", got.value,
                           got.data_valid, got.done, got.count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("indexed_deque_engine: mismatch");
         $finish;
      end
   end

   initial begin
      int made;
      int burst;
      int i;
      int grow;
      int gap;
      logic calm;

      // empty deque
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_POP_BACK, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_POP_FRONT, PLACE_FIXED, 0, '0, 3, 1'b0);
      add_op(idq_pkg::KIND_REMOVE, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 1, 32'h1111_1111, 0, 1'b0);
      // build up from both ends and the middle
      add_op(idq_pkg::KIND_PUSH_BACK, PLACE_FIXED, 0, 32'h0000_0000, 0, 1'b0);
      add_op(idq_pkg::KIND_PUSH_BACK, PLACE_FIXED, 0, 32'hFFFF_FFFF, 0, 1'b0);
      add_op(idq_pkg::KIND_PUSH_FRONT, PLACE_FIXED, 0, 32'h5A5A_5A5A, 7, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 1, 32'h0000_0001, 0, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 4, 32'h8000_0000, 0, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 2, 32'h1234_5678, 0, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 4, 32'h0000_FFFF, 0, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 0, 32'h0000_00A5, 0, 1'b0);
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 0, '1, 0, 1'b0);
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 7, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 8, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 2047, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_REMOVE, PLACE_FIXED, 2, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_REMOVE, PLACE_FIXED, 5, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 1024, 32'hDEAD_BEEF, 0, 1'b0);
      add_op(idq_pkg::KIND_REMOVE, PLACE_FIXED, 1024, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_POP_BACK, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_POP_FRONT, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_CLEAR, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_POP_BACK, PLACE_FIXED, 0, '0, 0, 1'b0);

      // random bursts with shifting bias toward growth or drain
      made = 0;
      while (made < 250) begin
         burst = $urandom_range(20, 60);
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 2))
            0:       grow = 60;
            1:       grow = 45;
            default: grow = 30;
         endcase
         for (i = 0; i < burst; i++) begin
            gap = calm ? 0 : $urandom_range(0, 19);
            add_random_op(grow, gap, (i == 0) && (made == 0 || $urandom_range(0, 2) == 0));
         end
         made += burst;
      end

      // fill to capacity, then exercise the full deque
      add_op(idq_pkg::KIND_CLEAR, PLACE_FIXED, 0, '0, 0, 1'b1);
      for (i = 0; i < idq_pkg::CAPACITY; i++) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
         case ($urandom_range(0, 9))
            0: add_op(idq_pkg::KIND_INSERT, PLACE_LIVE, 0, pick_value(), gap, 1'b0);
            1, 2, 3, 4: add_op(idq_pkg::KIND_PUSH_FRONT, PLACE_FIXED, 0, pick_value(),
                               gap, 1'b0);
            default: add_op(idq_pkg::KIND_PUSH_BACK, PLACE_FIXED, 0, pick_value(),
                            gap, 1'b0);
         endcase
      end
      add_op(idq_pkg::KIND_PUSH_BACK, PLACE_FIXED, 0, pick_value(), 0, 1'b0);
      add_op(idq_pkg::KIND_PUSH_FRONT, PLACE_FIXED, 0, pick_value(), 0, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 0, pick_value(), 0, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 512, pick_value(), 5, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_END, 0, pick_value(), 0, 1'b0);
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 1023, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 1024, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_REMOVE, PLACE_FIXED, 511, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 512, pick_value(), 0, 1'b0);
      add_op(idq_pkg::KIND_REMOVE, PLACE_FIXED, 512, '0, 11, 1'b0);
      add_op(idq_pkg::KIND_INSERT, PLACE_FIXED, 511, pick_value(), 0, 1'b0);
      for (i = 0; i < 8; i++) begin
         add_op(idq_pkg::KIND_READ, PLACE_LIVE, 0, '0, $urandom_range(0, 19), 1'b0);
      end
      add_op(idq_pkg::KIND_REMOVE, PLACE_FIXED, 1023, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_PUSH_BACK, PLACE_FIXED, 0, pick_value(), 0, 1'b0);
      add_op(idq_pkg::KIND_POP_FRONT, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_POP_BACK, PLACE_FIXED, 0, '0, 0, 1'b0);
      add_op(idq_pkg::KIND_CLEAR, PLACE_FIXED, 0, '0, 0, 1'b1);
      add_op(idq_pkg::KIND_READ, PLACE_FIXED, 0, '0, 0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || start || awaited_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (520) @(posedge clock);

      if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
         $display("indexed_deque_engine: match");
      end else begin
         $display("indexed_deque_engine: mismatch");
      end
      $finish;
   end

endmodule
